>>> sv/sdp_pkg.sv
// Shared types and constants for the SPS dimension parser.
package sdp_pkg;

    localparam int unsigned MAX_DIMENSION = 16384;
    localparam int unsigned MAX_POC_CYCLE = 256;
    localparam logic [4:0]  NAL_TYPE_SPS  = 5'd7;
    localparam logic [7:0]  EMU_BYTE      = 8'h03;
    localparam logic [5:0]  MAX_LEAD_ZERO = 6'd31;
    localparam int unsigned DIFF_W        = 38;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic        parse_ok;
        logic [14:0] pic_width;
        logic [14:0] pic_height;
    } t_out_beat;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic bit_en;
        logic sum;
        logic diff;
        logic load;
    } t_cmd;

endpackage

>>> sv/sdp_dp.sv
// Datapath: byte filter, bit-serial SPS syntax walker and final dimension math.
module sdp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdp_pkg::t_cmd      i_cmd,
    input  sdp_pkg::t_in_beat  i_in_beat,
    output sdp_pkg::t_out_beat o_out_beat
);
    import sdp_pkg::*;

    typedef enum logic [4:0] {
        S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_SEPCOL, S_DEPTHL,
        S_DEPTHC, S_BYPASS, S_MATRIX, S_LISTFLAG, S_DELTA, S_LOG2FN, S_POCTYPE,
        S_POCLSB, S_DELTAZERO, S_OFFNONREF, S_OFFTB, S_CYCLE, S_CYCLEOFF,
        S_MAXREF, S_GAPS, S_WIDTH, S_HEIGHT, S_FRAMEONLY, S_MBAFF, S_D8X8,
        S_CROPFLAG, S_CROP, S_DONE
    } t_step;

    t_step       r_step, n_step;
    logic [2:0]  r_bcnt, n_bcnt;
    logic [1:0]  r_pcnt, n_pcnt;
    logic [1:0]  r_zrun, n_zrun;
    logic [31:0] r_fs, n_fs;
    logic [5:0]  r_lz, n_lz;
    logic [5:0]  r_bl, n_bl;
    logic [7:0]  r_prof, n_prof;
    logic [31:0] r_chroma, n_chroma;
    logic        r_sep, n_sep;
    logic [3:0]  r_li, n_li;
    logic [6:0]  r_lp, n_lp;
    logic [7:0]  r_slast, n_slast;
    logic [8:0]  r_cyc, n_cyc;
    logic [31:0] r_wm, n_wm;
    logic [31:0] r_hu, n_hu;
    logic        r_fo, n_fo;
    logic [31:0] r_crop [4];
    logic [31:0] n_crop [4];
    logic        r_failed, n_failed;
    logic        r_take, n_take;
    logic [7:0]  r_byte, n_byte;

    // final math pipeline (payload, no reset)
    logic [31:0]         r_sw, r_sh, r_hu2;
    logic                r_shw;
    logic [1:0]          r_shh;
    logic [DIFF_W-1:0]   r_wd, r_ht;
    t_out_beat           r_out;

    // per-bit scratch
    logic        bit_in;
    logic [3:0]  fw;
    logic [31:0] fsn;
    logic        done;
    logic [31:0] v;
    logic [31:0] vp1;
    logic [7:0]  delta8;
    logic [7:0]  sn;
    logic [6:0]  lp1;
    logic [3:0]  li1;
    logic        wd_ok, ht_ok, ok;

    function automatic logic high_profile(input logic [7:0] p);
        logic r;
        r = 1'b0;
        case (p)
            8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
            8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // next parse state
    always_comb begin
        n_step = r_step; n_bcnt = r_bcnt; n_pcnt = r_pcnt; n_zrun = r_zrun;
        n_fs = r_fs; n_lz = r_lz; n_bl = r_bl; n_prof = r_prof;
        n_chroma = r_chroma; n_sep = r_sep; n_li = r_li; n_lp = r_lp;
        n_slast = r_slast; n_cyc = r_cyc; n_wm = r_wm; n_hu = r_hu; n_fo = r_fo;
        n_crop = r_crop; n_failed = r_failed; n_take = r_take; n_byte = r_byte;
        bit_in = r_byte[7];
        fsn    = {r_fs[30:0], bit_in};
        done   = 1'b0;
        v      = '0;
        delta8 = '0;
        sn     = '0;
        lp1    = r_lp + 7'd1;
        li1    = r_li + 4'd1;
        case (r_step)
            S_PROFILE, S_CONSTR, S_LEVEL: fw = 4'd8;
            S_SEPCOL, S_BYPASS, S_MATRIX, S_LISTFLAG, S_DELTAZERO, S_GAPS,
            S_FRAMEONLY, S_MBAFF, S_D8X8, S_CROPFLAG: fw = 4'd1;
            default: fw = 4'd0;
        endcase

        if (i_cmd.accept) begin
            // byte level: header check, emulation prevention, counters
            n_byte = i_in_beat.data_byte;
            n_take = 1'b0;
            if (r_bcnt == 3'd0) begin
                if (i_in_beat.data_byte[4:0] != NAL_TYPE_SPS) n_failed = 1'b1;
            end else if (r_zrun == 2'd2 && i_in_beat.data_byte == EMU_BYTE) begin
                n_zrun = 2'd0;
            end else begin
                n_take = 1'b1;
                if (i_in_beat.data_byte == 8'd0)
                    n_zrun = (r_zrun == 2'd2) ? 2'd2 : r_zrun + 2'd1;
                else
                    n_zrun = 2'd0;
                if (r_pcnt != 2'd3) n_pcnt = r_pcnt + 2'd1;
            end
            if (r_bcnt != 3'd4) n_bcnt = r_bcnt + 3'd1;
        end else if (i_cmd.bit_en) begin
            n_byte = {r_byte[6:0], 1'b0};
            if (r_take && !r_failed && r_step != S_DONE) begin
                // one bit into the current field
                if (fw != 4'd0) begin
                    n_fs = fsn;
                    n_bl = r_bl + 6'd1;
                    if ({2'd0, r_bl[3:0]} + 6'd1 >= {2'd0, fw}) begin
                        done = 1'b1;
                        v    = fsn;
                    end
                end else if (r_bl == 6'd0) begin
                    if (!bit_in) begin
                        if (r_lz >= MAX_LEAD_ZERO) n_failed = 1'b1;
                        else n_lz = r_lz + 6'd1;
                    end else if (r_lz == 6'd0) begin
                        done = 1'b1;
                    end else begin
                        // keep the leading one so the code value is fs - 1
                        n_bl = r_lz;
                        n_fs = 32'd1;
                    end
                end else begin
                    n_fs = fsn;
                    n_bl = r_bl - 6'd1;
                    if (r_bl == 6'd1) begin
                        done = 1'b1;
                        v    = fsn - 32'd1;
                    end
                end
            end
        end else if (i_cmd.load) begin
            // end of unit: back to the reset values
            n_step = S_PROFILE; n_bcnt = '0; n_pcnt = '0; n_zrun = '0;
            n_fs = '0; n_lz = '0; n_bl = '0; n_prof = '0; n_chroma = 32'd1;
            n_sep = 1'b0; n_li = '0; n_lp = '0; n_slast = 8'd8; n_cyc = '0;
            n_wm = '0; n_hu = '0; n_fo = 1'b0; n_failed = 1'b0; n_take = 1'b0;
            for (int k = 0; k < 4; k++) n_crop[k] = '0;
        end

        vp1 = v + 32'd1;

        // field complete: syntax step transition
        if (done) begin
            n_fs = '0; n_lz = '0; n_bl = '0;
            case (r_step)
                S_PROFILE: begin n_prof = v[7:0]; n_step = S_CONSTR; end
                S_CONSTR:  n_step = S_LEVEL;
                S_LEVEL:   n_step = S_SPSID;
                S_SPSID:   n_step = high_profile(r_prof) ? S_CHROMA : S_LOG2FN;
                S_CHROMA: begin
                    n_chroma = v;
                    n_step   = (v == 32'd3) ? S_SEPCOL : S_DEPTHL;
                end
                S_SEPCOL:  begin n_sep = v[0]; n_step = S_DEPTHL; end
                S_DEPTHL:  n_step = S_DEPTHC;
                S_DEPTHC:  n_step = S_BYPASS;
                S_BYPASS:  n_step = S_MATRIX;
                S_MATRIX: begin
                    n_li   = '0;
                    n_step = (v != 32'd0) ? S_LISTFLAG : S_LOG2FN;
                end
                S_LISTFLAG: begin
                    if (v != 32'd0) begin
                        n_lp = '0; n_slast = 8'd8; n_step = S_DELTA;
                    end else begin
                        n_li   = li1;
                        n_step = (li1 >= ((r_chroma != 32'd3) ? 4'd8 : 4'd12)) ?
                                 S_LOG2FN : S_LISTFLAG;
                    end
                end
                S_DELTA: begin
                    // only the low byte of the scale survives
                    delta8 = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
                    sn     = r_slast + delta8;
                    if (sn != 8'd0) n_slast = sn;
                    n_lp = lp1;
                    if (sn == 8'd0 || lp1 >= ((r_li < 4'd6) ? 7'd16 : 7'd64)) begin
                        n_li   = li1;
                        n_step = (li1 >= ((r_chroma != 32'd3) ? 4'd8 : 4'd12)) ?
                                 S_LOG2FN : S_LISTFLAG;
                    end
                end
                S_LOG2FN: n_step = S_POCTYPE;
                S_POCTYPE: begin
                    if (v == 32'd0)      n_step = S_POCLSB;
                    else if (v == 32'd1) n_step = S_DELTAZERO;
                    else                 n_step = S_MAXREF;
                end
                S_POCLSB:    n_step = S_MAXREF;
                S_DELTAZERO: n_step = S_OFFNONREF;
                S_OFFNONREF: n_step = S_OFFTB;
                S_OFFTB:     n_step = S_CYCLE;
                S_CYCLE: begin
                    if (v > MAX_POC_CYCLE) begin
                        n_failed = 1'b1;
                    end else begin
                        n_cyc  = v[8:0];
                        n_step = (v == 32'd0) ? S_MAXREF : S_CYCLEOFF;
                    end
                end
                S_CYCLEOFF: begin
                    n_cyc = r_cyc - 9'd1;
                    if (r_cyc == 9'd1) n_step = S_MAXREF;
                end
                S_MAXREF: n_step = S_GAPS;
                S_GAPS:   n_step = S_WIDTH;
                S_WIDTH:  begin n_wm = vp1; n_step = S_HEIGHT; end
                S_HEIGHT: begin n_hu = vp1; n_step = S_FRAMEONLY; end
                S_FRAMEONLY: begin
                    n_fo   = v[0];
                    n_step = v[0] ? S_D8X8 : S_MBAFF;
                end
                S_MBAFF: n_step = S_D8X8;
                S_D8X8:  n_step = S_CROPFLAG;
                S_CROPFLAG: begin
                    n_li   = '0;
                    n_step = (v != 32'd0) ? S_CROP : S_DONE;
                end
                S_CROP: begin
                    n_crop[r_li[1:0]] = v;
                    n_li = li1;
                    if (li1 >= 4'd4) n_step = S_DONE;
                end
                default: n_step = r_step;
            endcase
        end
    end

    // result checks on the registered differences
    always_comb begin
        wd_ok = !r_wd[DIFF_W-1] && (r_wd != '0) && (r_wd <= DIFF_W'(MAX_DIMENSION));
        ht_ok = !r_ht[DIFF_W-1] && (r_ht != '0) && (r_ht <= DIFF_W'(MAX_DIMENSION));
        ok    = !r_failed && (r_bcnt == 3'd4) && (r_pcnt == 2'd3) &&
                (r_step == S_DONE) && wd_ok && ht_ok;
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_PROFILE; r_bcnt <= '0; r_pcnt <= '0; r_zrun <= '0;
            r_fs <= '0; r_lz <= '0; r_bl <= '0; r_prof <= '0; r_chroma <= 32'd1;
            r_sep <= 1'b0; r_li <= '0; r_lp <= '0; r_slast <= 8'd8; r_cyc <= '0;
            r_wm <= '0; r_hu <= '0; r_fo <= 1'b0; r_failed <= 1'b0; r_take <= 1'b0;
            for (int k = 0; k < 4; k++) r_crop[k] <= '0;
        end else begin
            r_step <= n_step; r_bcnt <= n_bcnt; r_pcnt <= n_pcnt; r_zrun <= n_zrun;
            r_fs <= n_fs; r_lz <= n_lz; r_bl <= n_bl; r_prof <= n_prof;
            r_chroma <= n_chroma; r_sep <= n_sep; r_li <= n_li; r_lp <= n_lp;
            r_slast <= n_slast; r_cyc <= n_cyc; r_wm <= n_wm; r_hu <= n_hu;
            r_fo <= n_fo; r_failed <= n_failed; r_take <= n_take;
            r_crop <= n_crop;
        end
    end

    // byte shifter and final math stages
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (i_cmd.sum) begin
            r_sw  <= r_crop[0] + r_crop[1];
            r_sh  <= r_crop[2] + r_crop[3];
            r_hu2 <= r_fo ? r_hu : {r_hu[30:0], 1'b0};
            r_shw <= (r_chroma == 32'd1 || r_chroma == 32'd2) &&
                     !(r_chroma == 32'd0 || r_sep);
            r_shh <= {1'b0, (r_chroma == 32'd1) && !r_sep} + {1'b0, !r_fo};
        end
        if (i_cmd.diff) begin
            r_wd <= ({6'd0, r_wm} << 4) - ({6'd0, r_sw} << r_shw);
            r_ht <= ({6'd0, r_hu2} << 4) - ({6'd0, r_sh} << r_shh);
        end
        if (i_cmd.load) begin
            r_out.parse_ok   <= ok;
            r_out.pic_width  <= ok ? r_wd[14:0] : 15'd0;
            r_out.pic_height <= ok ? r_ht[14:0] : 15'd0;
        end
    end

    assign o_out_beat = r_out;

endmodule

>>> sv/sdp_ctrl.sv
// Controller: byte handshake, bit sequencer and result beat hand-off.
module sdp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sdp_pkg::t_cmd o_cmd
);
    import sdp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_BITS, S_SUM, S_DIFF, S_LOAD} t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic       r_last;
    logic       r_out_valid;
    t_cmd       cmd;

    // commands decoded from state
    always_comb begin
        cmd.accept = (r_state == S_IDLE) && i_in_valid;
        cmd.bit_en = (r_state == S_BITS);
        cmd.sum    = (r_state == S_SUM);
        cmd.diff   = (r_state == S_DIFF);
        cmd.load   = (r_state == S_LOAD) && (!r_out_valid || !i_out_stall);
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (cmd.accept) begin
                        r_state <= S_BITS;
                        r_cnt   <= 3'd7;
                        r_last  <= i_last;
                    end
                end
                S_BITS: begin
                    if (r_cnt == 3'd0) r_state <= r_last ? S_SUM : S_IDLE;
                    else r_cnt <= r_cnt - 3'd1;
                end
                S_SUM:  r_state <= S_DIFF;
                S_DIFF: r_state <= S_LOAD;
                S_LOAD: if (cmd.load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_accept_starts_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> (r_state == S_BITS && r_cnt == 3'd7))
        else $error("accepted byte did not start the bit sequence");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending beat");
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(cmd.load))
        else $error("result beat appeared without a load");
    a_sum_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_last && $past(r_state == S_BITS)))
        else $error("final math started without a last byte");

endmodule

>>> sv/h264_sps_dimension_parser_unit.sv
// Top level of the H.264 SPS dimension parser.
//
//  channel | direction | payload    | handshake
//  in      | input     | t_in_beat  | i_in_valid / o_in_stall
//  out     | output    | t_out_beat | o_out_valid / i_out_stall
//
// Each byte beat is accepted, then fed one payload bit per cycle through the
// syntax sequencer. A last byte then runs the crop math (sum, difference) before
// the result is loaded into the output register. Synchronous active-low reset
// returns the parser to the header-byte state. A stalled result beat holds the
// final stage, so a new unit can start only once it has been taken or is leaving.
module h264_sps_dimension_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sdp_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sdp_pkg::t_out_beat o_out_beat
);
    import sdp_pkg::*;

    t_cmd cmd;

    sdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in_beat.last_byte),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    sdp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_beat  (i_in_beat),
        .o_out_beat (o_out_beat)
    );

endmodule

>>> tb/sv/h264_sps_dimension_parser_unit_tb.sv
// Testbench for the H.264 SPS dimension parser: byte beats in, checked results out.
module h264_sps_dimension_parser_unit_tb;
    import sdp_pkg::*;

    // Syntax positions of the SPS walker
    typedef enum int {
        ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPCOL, ST_DEPTHL,
        ST_DEPTHC, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTA, ST_LOG2FN, ST_POCTYPE,
        ST_POCLSB, ST_DELTAZERO, ST_OFFNONREF, ST_OFFTB, ST_CYCLE, ST_CYCLEOFF,
        ST_MAXREF, ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FRAMEONLY, ST_MBAFF, ST_D8X8,
        ST_CROPFLAG, ST_CROP, ST_DONE
    } t_step;

    localparam int LIMIT_CYCLES = 3000000;

    // Scoreboard: SPS walker state and pending dimension results
    class sps_scoreboard;
        t_step       step;
        int unsigned nbytes, npay, zrun, shreg, nlz, nleft, profile, chroma, sep;
        int unsigned lidx, lpos, slast, snext, cyc, wmbs, hunits, frm, failed;
        int unsigned crop[4];
        t_out_beat   dims_q[$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            step = ST_PROFILE;
            nbytes = 0; npay = 0; zrun = 0; shreg = 0; nlz = 0; nleft = 0;
            profile = 0; chroma = 1; sep = 0; lidx = 0; lpos = 0;
            slast = 8; snext = 8; cyc = 0; wmbs = 0; hunits = 0; frm = 0;
            crop[0] = 0; crop[1] = 0; crop[2] = 0; crop[3] = 0; failed = 0;
        endfunction

        function int unsigned fixed_bits(t_step s);
            case (s)
                ST_PROFILE, ST_CONSTR, ST_LEVEL: return 8;
                ST_SEPCOL, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTAZERO, ST_GAPS,
                ST_FRAMEONLY, ST_MBAFF, ST_D8X8, ST_CROPFLAG: return 1;
                default: return 0;
            endcase
        endfunction

        function bit is_high(int unsigned p);
            case (p)
                100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135: return 1;
                default: return 0;
            endcase
        endfunction

        function void advance_list();
            lidx++;
            step = (lidx >= ((chroma != 3) ? 8 : 12)) ? ST_LOG2FN : ST_LISTFLAG;
        endfunction

        function void field(int unsigned v);
            int unsigned dl;
            shreg = 0; nlz = 0; nleft = 0;
            case (step)
                ST_PROFILE: begin profile = v & 8'hff; step = ST_CONSTR; end
                ST_CONSTR: step = ST_LEVEL;
                ST_LEVEL: step = ST_SPSID;
                ST_SPSID: step = is_high(profile) ? ST_CHROMA : ST_LOG2FN;
                ST_CHROMA: begin
                    chroma = v;
                    step = (v == 3) ? ST_SEPCOL : ST_DEPTHL;
                end
                ST_SEPCOL: begin sep = v & 1; step = ST_DEPTHL; end
                ST_DEPTHL: step = ST_DEPTHC;
                ST_DEPTHC: step = ST_BYPASS;
                ST_BYPASS: step = ST_MATRIX;
                ST_MATRIX: begin lidx = 0; step = v ? ST_LISTFLAG : ST_LOG2FN; end
                ST_LISTFLAG: begin
                    if (v) begin
                        lpos = 0; slast = 8; snext = 8; step = ST_DELTA;
                    end else advance_list();
                end
                ST_DELTA: begin
                    dl = (v & 1) ? (v / 2 + 1) : (0 - v / 2);
                    snext = (slast + dl + 256) & 8'hff;
                    if (snext != 0) slast = snext;
                    lpos++;
                    if (snext == 0 || lpos >= ((lidx < 6) ? 16 : 64)) advance_list();
                end
                ST_LOG2FN: step = ST_POCTYPE;
                ST_POCTYPE: step = (v == 0) ? ST_POCLSB : (v == 1) ? ST_DELTAZERO : ST_MAXREF;
                ST_POCLSB: step = ST_MAXREF;
                ST_DELTAZERO: step = ST_OFFNONREF;
                ST_OFFNONREF: step = ST_OFFTB;
                ST_OFFTB: step = ST_CYCLE;
                ST_CYCLE: begin
                    if (v > MAX_POC_CYCLE) failed = 1;
                    else begin
                        cyc = v;
                        step = (v == 0) ? ST_MAXREF : ST_CYCLEOFF;
                    end
                end
                ST_CYCLEOFF: begin cyc--; if (cyc == 0) step = ST_MAXREF; end
                ST_MAXREF: step = ST_GAPS;
                ST_GAPS: step = ST_WIDTH;
                ST_WIDTH: begin wmbs = v + 1; step = ST_HEIGHT; end
                ST_HEIGHT: begin hunits = v + 1; step = ST_FRAMEONLY; end
                ST_FRAMEONLY: begin frm = v & 1; step = frm ? ST_D8X8 : ST_MBAFF; end
                ST_MBAFF: step = ST_D8X8;
                ST_D8X8: step = ST_CROPFLAG;
                ST_CROPFLAG: begin lidx = 0; step = v ? ST_CROP : ST_DONE; end
                ST_CROP: begin
                    crop[lidx & 3] = v;
                    lidx++;
                    if (lidx >= 4) step = ST_DONE;
                end
                default: ;
            endcase
        endfunction

        function void push_bit(int unsigned b);
            int unsigned w;
            w = fixed_bits(step);
            if (w != 0) begin
                shreg = (shreg << 1) | b;
                nleft++;
                if (nleft >= w) field(shreg);
            end else if (nleft == 0) begin
                if (b == 0) begin
                    if (nlz >= MAX_LEAD_ZERO) failed = 1;
                    else nlz++;
                end else if (nlz == 0) field(0);
                else begin
                    nleft = nlz; shreg = 0;
                end
            end else begin
                shreg = (shreg << 1) | b;
                nleft--;
                if (nleft == 0) field(((32'd1 << nlz) - 1) + shreg);
            end
        endfunction

        // Note one accepted byte beat
        function void note_byte(t_in_beat bt);
            int unsigned b;
            bit ok;
            longint wd, ht;
            int unsigned sw, sh, nf, csum, hsum;
            t_out_beat r;
            b = bt.data_byte;
            if (nbytes == 0) begin
                if ((b & 5'h1f) != NAL_TYPE_SPS) failed = 1;
            end else if (zrun >= 2 && b == EMU_BYTE) begin
                zrun = 0;
            end else begin
                zrun = (b == 0) ? ((zrun < 2) ? zrun + 1 : 2) : 0;
                if (npay < 3) npay++;
                for (int i = 7; i >= 0; i--) begin
                    if (failed || step == ST_DONE) break;
                    push_bit((b >> i) & 1);
                end
            end
            if (nbytes < 4) nbytes++;
            if (!bt.last_byte) return;
            ok = !failed && nbytes >= 4 && npay >= 3 && step == ST_DONE;
            wd = 0; ht = 0;
            if (ok) begin
                sw = (chroma == 1 || chroma == 2) ? 2 : 1;
                sh = (chroma == 1) ? 2 : 1;
                nf = 2 - frm;
                if (chroma == 0 || sep) begin sw = 1; sh = 1; end
                csum = crop[0] + crop[1];
                wd = longint'(wmbs) * 16 - longint'(csum) * sw;
                hsum = nf * hunits;
                csum = crop[2] + crop[3];
                ht = longint'(hsum) * 16 - longint'(csum) * longint'(sh * nf);
                if (wd <= 0 || ht <= 0 || wd > MAX_DIMENSION || ht > MAX_DIMENSION)
                    ok = 0;
            end
            r.parse_ok = ok;
            r.pic_width = ok ? wd[14:0] : '0;
            r.pic_height = ok ? ht[14:0] : '0;
            dims_q.insert(dims_q.size(), r);
            clear();
        endfunction

        // Compare one result beat against the oldest expected dimensions
        function void check_dims(t_out_beat got);
            t_out_beat want;
            if (dims_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = dims_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("dims mismatch: expected ok=%0d w=%0d h=%0d got ok=%0d w=%0d h=%0d",
                             want.parse_ok, want.pic_width, want.pic_height,
                             got.parse_ok, got.pic_width, got.pic_height);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_beat;

    sps_scoreboard sb;
    int unsigned   cycles;
    bit            sink_idle;

    h264_sps_dimension_parser_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_beat(o_out_beat)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Bit writer for building SPS payloads
    bit   wbits[$];
    byte  ubytes[$];

    function void put_bits(int unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) wbits.insert(wbits.size(), (v >> i) & 1);
    endfunction

    function void put_ue(int unsigned v);
        longint unsigned x;
        int n;
        x = longint'(v) + 1;
        n = 0;
        while ((x >> (n + 1)) != 0) n++;
        for (int i = 0; i < n; i++) wbits.insert(wbits.size(), 1'b0);
        for (int i = n; i >= 0; i--) wbits.insert(wbits.size(), (x >> i) & 1);
    endfunction

    // Pack bits into bytes, add header and emulation prevention
    function void finish_unit(int unsigned hdr);
        int unsigned zr, b;
        wbits.insert(wbits.size(), 1'b1);
        while (wbits.size() % 8 != 0) wbits.insert(wbits.size(), 1'b0);
        ubytes.delete();
        ubytes.insert(ubytes.size(), hdr[7:0]);
        zr = 0;
        while (wbits.size() > 0) begin
            b = 0;
            for (int i = 0; i < 8; i++) b = (b << 1) | wbits.pop_front();
            if (zr >= 2 && b <= 3) begin
                ubytes.insert(ubytes.size(), 8'h03);
                zr = 0;
            end
            ubytes.insert(ubytes.size(), b[7:0]);
            zr = (b == 0) ? zr + 1 : 0;
        end
    endfunction

    // Build a well-formed SPS with random content
    function void build_sps(int unsigned prof, int unsigned cf, int unsigned poc,
                            int unsigned wm, int unsigned hm, bit frame, bit crop,
                            bit lists);
        wbits.delete();
        put_bits(prof, 8); put_bits($urandom, 8); put_bits($urandom, 8);
        put_ue($urandom_range(0, 31));
        if (prof inside {100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135}) begin
            put_ue(cf);
            if (cf == 3) put_bits($urandom_range(0, 1), 1);
            put_ue($urandom_range(0, 6)); put_ue($urandom_range(0, 6));
            put_bits($urandom_range(0, 1), 1);
            put_bits(lists, 1);
            if (lists) begin
                for (int l = 0; l < ((cf != 3) ? 8 : 12); l++) begin
                    if ($urandom_range(0, 2) == 0) put_bits(0, 1);
                    else begin
                        put_bits(1, 1);
                        for (int k = 0; k < ((l < 6) ? 16 : 64); k++)
                            put_ue($urandom_range(0, ($urandom_range(0, 9) == 0) ? 300 : 6));
                    end
                end
            end
        end
        put_ue($urandom_range(0, 12));
        put_ue(poc);
        if (poc == 0) put_ue($urandom_range(0, 12));
        else if (poc == 1) begin
            int unsigned nc;
            put_bits($urandom_range(0, 1), 1);
            put_ue($urandom); put_ue($urandom_range(0, 1000));
            nc = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 5);
            put_ue(nc);
            for (int k = 0; k < nc && k <= 256; k++) put_ue($urandom_range(0, 50));
        end
        put_ue($urandom_range(0, 16)); put_bits($urandom_range(0, 1), 1);
        put_ue(wm); put_ue(hm);
        put_bits(frame, 1);
        if (!frame) put_bits($urandom_range(0, 1), 1);
        put_bits($urandom_range(0, 1), 1);
        put_bits(crop, 1);
        if (crop) for (int k = 0; k < 4; k++)
            put_ue(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 9));
        for (int k = 0; k < $urandom_range(0, 3); k++) put_bits($urandom, 8);
        finish_unit(8'h67 | ($urandom_range(0, 1) << 7) | 8'h00);
    endfunction

    // Send one byte beat, honoring stall; valid stays up when no gap follows
    task automatic send_byte(byte unsigned b, bit last);
        t_in_beat bt;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bt.data_byte = b;
        bt.last_byte = last;
        i_in_beat <= bt;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(bt);
    endtask

    task automatic send_unit();
        for (int i = 0; i < ubytes.size(); i++)
            send_byte(ubytes[i], i == ubytes.size() - 1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.dims_q.size() != 0) @(posedge i_clk);
    endtask

    // Random sink stall, redrawn per result beat
    int sink_wait;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) sb.check_dims(o_out_beat);
            if (sink_idle) i_out_stall <= 1'b0;
            else if (o_out_valid && !i_out_stall) begin
                sink_wait = $urandom_range(0, 14);
                i_out_stall <= (sink_wait != 0);
            end else if (sink_wait > 0) begin
                sink_wait--;
                i_out_stall <= (sink_wait != 0);
            end
        end
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned nsent;
        sb = new();
        sink_idle = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed units: baseline, high profile, 4:4:4, POC types, crops
        build_sps(66, 1, 0, 19, 14, 1, 0, 0); send_unit();
        build_sps(100, 1, 1, 119, 67, 1, 1, 1); send_unit();
        build_sps(244, 3, 2, 0, 0, 0, 1, 1); send_unit();
        build_sps(100, 0, 0, 1023, 1023, 1, 0, 0); send_unit();
        build_sps(122, 2, 2, 1024, 511, 0, 1, 0); send_unit();
        // wrong header type
        ubytes = '{8'h68, 8'h42, 8'h00, 8'h1e, 8'hff};
        send_unit();
        // short units
        ubytes = '{8'h67, 8'h42, 8'h00}; send_unit();
        ubytes = '{8'h67}; send_unit();
        ubytes = '{8'h67, 8'h00, 8'h00, 8'h03, 8'h00}; send_unit();
        // long prefix of zeros
        ubytes = '{8'h67, 8'h42, 8'h00, 8'h1e, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h01};
        send_unit();
        // sender pauses until every result is back
        drain();
        sink_idle = 1;
        build_sps(66, 1, 0, 39, 29, 1, 0, 0); send_unit();
        drain();
        sink_idle = 0;

        // Random phase: mostly well-formed units, some noise and truncations
        nsent = 0;
        while (nsent < 1700) begin
            int unsigned kind, prof, cut;
            kind = $urandom_range(0, 9);
            prof = ($urandom_range(0, 1) == 0) ? 66 :
                   (($urandom_range(0, 1) == 0) ? 100 : 244);
            build_sps(prof, $urandom_range(0, 3), $urandom_range(0, 2),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) : $urandom_range(0, 60),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) : $urandom_range(0, 60),
                      $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 7) == 0);
            if (kind == 0) begin
                cut = $urandom_range(1, ubytes.size());
                while (ubytes.size() > cut) void'(ubytes.pop_back());
            end else if (kind == 1) begin
                for (int i = 0; i < ubytes.size(); i++) ubytes[i] = $urandom;
            end else if (kind == 2) begin
                ubytes[$urandom_range(0, ubytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            send_unit();
            nsent += ubytes.size();
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.dims_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
